>>> design/hlfr_pkg.sv
// Shared types and constants for the header/length frame receiver.
// Holds the beat structs, the queue entry and the ring sizing constants.
// No dependencies.
package hlfr_pkg;

	localparam int RING_DEPTH    = 256;
	localparam int MAX_FRAMES    = 8;
	localparam int LENGTH_OFFSET = 4;
	localparam int MIN_ROOM      = 8;

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int ROOM_W = $clog2(RING_DEPTH + 1);
	localparam int PEND_W = $clog2(MAX_FRAMES + 1);
	localparam int CNT_W  = 16;
	localparam int SUM_W  = ((ROOM_W > CNT_W + 1) ? ROOM_W : CNT_W + 1) + 1;

	localparam logic [7:0] HEADER_RESET = 8'h00;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_HEADER,
		KIND_RELEASE
	} kind_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
		logic [8:0] release_length;
	} in_item_t;

	typedef struct packed {
		logic        store_write;
		logic [7:0]  store_address;
		logic [7:0]  store_data;
		logic        frame_done;
		logic        frame_dropped;
		logic [15:0] frame_length;
		logic [7:0]  frame_start_address;
		logic [8:0]  room_left_out;
		logic [3:0]  frames_pending_out;
	} out_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] rx_byte;
		logic [8:0] release_length;
	} entry_t;

endpackage

>>> design/header_length_frame_receiver.sv
// A beat waits in the queue; the back end then registers its result beat.
// One beat per cycle unless out_ready stalls; each pop settles all frame state.
// A two-entry queue and the output register keep both sides moving independently.
// Reset (arst_n low, asynchronous): hunting for a header, ring empty, header byte 0.
// Depends on hlfr_pkg, hlfr_front, hlfr_queue and hlfr_back.
module header_length_frame_receiver import hlfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic   push;
	entry_t push_entry;
	logic   queue_full;
	logic   pop;
	logic   head_valid;
	entry_t head;

	hlfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	hlfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	hlfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

>>> design/hlfr_front.sv
// Front end: takes input beats, compares them against the header register and
// pushes classified entries into the queue. Also holds the header register.
// Depends on hlfr_pkg.
module hlfr_front import hlfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       queue_full,
	output logic       push,
	output entry_t     push_entry
);

	logic [7:0] header_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			header_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = !queue_full;
	assign push      = in_valid && !queue_full;

	always_comb begin
		push_entry.rx_byte        = in_data.rx_byte;
		push_entry.release_length = in_data.release_length;
		if (in_data.mode) begin
			push_entry.kind = KIND_RELEASE;
		end else if (in_data.rx_byte == header_q) begin
			push_entry.kind = KIND_HEADER;
		end else begin
			push_entry.kind = KIND_DATA;
		end
	end

endmodule

>>> design/hlfr_queue.sv
// Two-entry queue between the front end and the back end.
// Lets either side stall without holding up the other.
// Depends on hlfr_pkg.
module hlfr_queue import hlfr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	entry_t     slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_q];

endmodule

>>> design/hlfr_back.sv
// Back end: frame state, ring pointer bookkeeping and the output register.
// Executes one queue entry per cycle whenever the output register can take a beat.
// Depends on hlfr_pkg.
module hlfr_back import hlfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  entry_t    head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic              in_frame_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [15:0]       expected_q;
	logic [7:0]        prev_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  start_q;
	logic [ROOM_W-1:0] room_q;
	logic [PEND_W-1:0] pend_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              in_frame_n;
	logic [CNT_W-1:0]  cnt_n;
	logic              ovf_n;
	logic [15:0]       expected_n;
	logic [7:0]        prev_n;
	logic [PTR_W-1:0]  ptr_n;
	logic [PTR_W-1:0]  start_n;
	logic [ROOM_W-1:0] room_n;
	logic [PEND_W-1:0] pend_n;
	out_item_t         res;

	logic [PTR_W-1:0]  ptr_inc;
	logic [CNT_W:0]    cnt_ext;
	logic [ROOM_W-1:0] room_after;
	logic [SUM_W-1:0]  rel_sum;
	logic [SUM_W-1:0]  drop_sum;

	assign pop = head_valid && (!out_valid_q || out_ready);

	assign ptr_inc    = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
	assign cnt_ext    = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign room_after = (room_q != '0) ? room_q - ROOM_W'(1) : room_q;
	assign rel_sum    = SUM_W'(room_q) + SUM_W'(head.release_length);

	always_comb begin
		in_frame_n = in_frame_q;
		cnt_n      = cnt_q;
		ovf_n      = ovf_q;
		expected_n = expected_q;
		prev_n     = prev_q;
		ptr_n      = ptr_q;
		start_n    = start_q;
		room_n     = room_q;
		pend_n     = pend_q;
		drop_sum   = '0;
		res        = '0;

		unique case (head.kind)
			KIND_RELEASE: begin
				room_n = (rel_sum > SUM_W'(RING_DEPTH)) ? ROOM_W'(RING_DEPTH)
					: ROOM_W'(rel_sum);
				if (pend_q != '0) begin
					pend_n = pend_q - PEND_W'(1);
				end
				res.frame_length = cnt_q;
			end
			KIND_HEADER, KIND_DATA: begin
				if (!in_frame_q) begin
					if (head.kind == KIND_HEADER && room_q >= ROOM_W'(MIN_ROOM)) begin
						res.store_write   = 1'b1;
						res.store_address = 8'(ptr_q);
						res.store_data    = head.rx_byte;
						start_n    = ptr_q;
						ptr_n      = ptr_inc;
						room_n     = room_after;
						in_frame_n = 1'b1;
						cnt_n      = CNT_W'(1);
						ovf_n      = 1'b0;
						expected_n = '0;
						prev_n     = head.rx_byte;
						res.frame_length = 16'd1;
					end
				end else begin
					res.store_write   = 1'b1;
					res.store_address = 8'(ptr_q);
					res.store_data    = head.rx_byte;
					ptr_n  = ptr_inc;
					room_n = room_after;
					cnt_n  = cnt_ext[CNT_W-1:0];
					// Once the count has passed the 16-bit range it can never match again.
					ovf_n  = ovf_q | cnt_ext[CNT_W];
					if (!ovf_n && cnt_n == CNT_W'(LENGTH_OFFSET)) begin
						expected_n = {prev_q, head.rx_byte};
					end else if (expected_q != '0 && !ovf_n && cnt_n == expected_q) begin
						pend_n     = pend_q + PEND_W'(1);
						in_frame_n = 1'b0;
						expected_n = '0;
						res.frame_done = 1'b1;
					end
					prev_n = head.rx_byte;
					res.frame_length = cnt_n;
					if (room_after == '0 || pend_n >= PEND_W'(MAX_FRAMES)) begin
						// The pointer advanced by exactly the count, so the rewind
						// lands back on the frame's header slot.
						drop_sum = SUM_W'(room_after) + SUM_W'({ovf_n, cnt_n});
						ptr_n    = start_q;
						room_n   = (drop_sum > SUM_W'(RING_DEPTH)) ? ROOM_W'(RING_DEPTH)
							: ROOM_W'(drop_sum);
						if (pend_n >= PEND_W'(MAX_FRAMES)) begin
							pend_n = pend_n - PEND_W'(1);
						end
						in_frame_n = 1'b0;
						expected_n = '0;
						res.frame_done    = 1'b0;
						res.frame_dropped = 1'b1;
					end
					if (!in_frame_n) begin
						cnt_n = '0;
						ovf_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase

		res.frame_start_address = 8'(start_n);
		res.room_left_out       = 9'(room_n);
		res.frames_pending_out  = 4'(pend_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			expected_q  <= '0;
			prev_q      <= '0;
			ptr_q       <= '0;
			start_q     <= '0;
			room_q      <= ROOM_W'(RING_DEPTH);
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				in_frame_q  <= in_frame_n;
				cnt_q       <= cnt_n;
				ovf_q       <= ovf_n;
				expected_q  <= expected_n;
				prev_q      <= prev_n;
				ptr_q       <= ptr_n;
				start_q     <= start_n;
				room_q      <= room_n;
				pend_q      <= pend_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> design/hlfr_checker.sv
// Port-level checks for the frame receiver, attached by the bind below.
// Depends on hlfr_pkg and the header_length_frame_receiver ports.
module hlfr_checker import hlfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input in_item_t   in_data,
	input logic       out_valid,
	input logic       out_ready,
	input out_item_t  out_data
);

	// A finished frame and a dropped frame cannot come out of the same beat.
	a_done_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.frame_done && out_data.frame_dropped))
		else $error("frame_done and frame_dropped both set");

	// Completing a frame always writes its last byte and leaves it pending.
	a_done_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |->
			out_data.store_write && out_data.frames_pending_out != 4'd0)
		else $error("frame_done without a write or a pending frame");

	// Free room never exceeds the ring.
	a_room_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.room_left_out <= 9'(RING_DEPTH))
		else $error("room_left_out beyond ring depth");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// A waiting input beat holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while waiting");

endmodule

bind header_length_frame_receiver hlfr_checker u_hlfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> tb/hlfr_checker.sv
// Scoreboard for the header/length frame receiver: tracks the header register, predicts
// one result beat per accepted input beat and compares results in order.
// Depends on hlfr_pkg for the beat structs and the ring sizing constants.
module hlfr_scoreboard import hlfr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  in_item_t        in_data,
	input  logic            out_valid,
	input  logic            out_ready,
	input  out_item_t       out_data,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [7:0]      cfg_data,
	output int unsigned     fail_count,
	output int unsigned     beats_outstanding,
	output int unsigned     frames_completed,
	output int unsigned     frames_discarded
);

	logic [7:0]  hdr_value;
	logic        framing;
	int unsigned count;
	int unsigned length_field;
	logic [7:0]  last_byte;
	int unsigned wr_ptr;
	int unsigned head_ptr;
	int unsigned room_free;
	int unsigned frames_held;

	out_item_t   expected_q[$];

	task automatic store_byte(input logic [7:0] b, inout out_item_t r);
		r.store_write   = 1'b1;
		r.store_address = wr_ptr[7:0];
		r.store_data    = b;
		wr_ptr = (wr_ptr + 1) % RING_DEPTH;
		if (room_free > 0)
			room_free--;
	endtask

	task automatic predict_result(input in_item_t beat, output out_item_t r);
		int unsigned sum;
		int unsigned back;
		r = '0;
		if (beat.mode) begin
			sum = room_free + beat.release_length;
			room_free = (sum > RING_DEPTH) ? RING_DEPTH : sum;
			if (frames_held > 0)
				frames_held--;
			r.frame_length = framing ? count[15:0] : 16'd0;
		end else if (!framing) begin
			if (beat.rx_byte == hdr_value && room_free >= MIN_ROOM) begin
				head_ptr = wr_ptr;
				store_byte(beat.rx_byte, r);
				framing      = 1'b1;
				count        = 1;
				length_field = 0;
				last_byte    = beat.rx_byte;
			end
			r.frame_length = framing ? count[15:0] : 16'd0;
		end else begin
			store_byte(beat.rx_byte, r);
			count++;
			// The length is big-endian and spans the beat before this one and this one.
			if (count == LENGTH_OFFSET) begin
				length_field = {last_byte, beat.rx_byte};
			end else if (length_field != 0 && count == length_field) begin
				frames_held++;
				framing      = 1'b0;
				length_field = 0;
				r.frame_done = 1'b1;
			end
			last_byte = beat.rx_byte;
			r.frame_length = count[15:0];
			// A full ring or a full frame table discards the frame, even one that just completed.
			if (room_free == 0 || frames_held >= MAX_FRAMES) begin
				back = count % RING_DEPTH;
				wr_ptr = (wr_ptr + RING_DEPTH - back) % RING_DEPTH;
				room_free += count;
				if (room_free > RING_DEPTH)
					room_free = RING_DEPTH;
				if (frames_held >= MAX_FRAMES)
					frames_held--;
				framing         = 1'b0;
				length_field    = 0;
				r.frame_done    = 1'b0;
				r.frame_dropped = 1'b1;
			end
			if (!framing)
				count = 0;
		end
		r.frame_start_address = head_ptr[7:0];
		r.room_left_out       = room_free[8:0];
		r.frames_pending_out  = frames_held[3:0];
	endtask

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t want;
		out_item_t fresh;
		if (!arst_n) begin
			hdr_value    = HEADER_RESET;
			framing      = 1'b0;
			count        = 0;
			length_field = 0;
			last_byte    = 8'h00;
			wr_ptr       = 0;
			head_ptr     = 0;
			room_free    = RING_DEPTH;
			frames_held  = 0;
			expected_q.delete();
			beats_outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: result beat %h arrived with nothing expected", $time,
						out_data);
				end else begin
					want = expected_q.pop_front();
					check_field("store_write", want.store_write, out_data.store_write);
					check_field("store_address", want.store_address, out_data.store_address);
					check_field("store_data", want.store_data, out_data.store_data);
					check_field("frame_done", want.frame_done, out_data.frame_done);
					check_field("frame_dropped", want.frame_dropped, out_data.frame_dropped);
					check_field("frame_length", want.frame_length, out_data.frame_length);
					check_field("frame_start_address", want.frame_start_address,
						out_data.frame_start_address);
					check_field("room_left_out", want.room_left_out, out_data.room_left_out);
					check_field("frames_pending_out", want.frames_pending_out,
						out_data.frames_pending_out);
					frames_completed += want.frame_done;
					frames_discarded += want.frame_dropped;
				end
			end
			if (cfg_valid && cfg_ready)
				hdr_value = cfg_data;
			if (in_valid && in_ready) begin
				predict_result(in_data, fresh);
				expected_q.push_back(fresh);
			end
			beats_outstanding <= expected_q.size();
		end
	end

endmodule

>>> tb/header_length_frame_receiver_test.sv
// Top of the frame receiver testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on hlfr_pkg, the header_length_frame_receiver block and the hlfr_scoreboard module.
module header_length_frame_receiver_test;
	import hlfr_pkg::*;

	localparam logic MODE_BYTE    = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;
	localparam int   WATCHDOG_LIMIT = 4000;
	localparam int   PHASE_BUDGET   = 130;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;

	int unsigned fail_count;
	int unsigned beats_outstanding;
	int unsigned frames_completed;
	int unsigned frames_discarded;

	logic [7:0]  cur_header = HEADER_RESET;
	int unsigned burst_left = 0;
	int unsigned beats_sent = 0;
	int unsigned header_writes = 0;
	int unsigned idle_cycles = 0;
	logic [31:0] rx_tick = 0;

	always #10 clk = ~clk;

	header_length_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	hlfr_scoreboard u_scoreboard (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.in_data           (in_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_data          (out_data),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.fail_count        (fail_count),
		.beats_outstanding (beats_outstanding),
		.frames_completed  (frames_completed),
		.frames_discarded  (frames_discarded)
	);

	// The result side cycles through four stall styles, selected by bits 9 and 8 of rx_tick.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 32'd1;
		case (rx_tick[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= (rx_tick % 3) != 0;
			2'd2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (rx_tick[4:0] < 5'd20);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[header_length_frame_receiver] ERROR");
			$finish;
		end
	end

	task automatic send_beat(input in_item_t beat);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		beats_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_item_t beat;
		beat.mode           = MODE_BYTE;
		beat.rx_byte        = b;
		beat.release_length = 9'($urandom_range(0, 256));
		send_beat(beat);
	endtask

	task automatic send_release(input logic [8:0] freed);
		in_item_t beat;
		beat.mode           = MODE_RELEASE;
		beat.rx_byte        = 8'($urandom_range(0, 255));
		beat.release_length = freed;
		send_beat(beat);
	endtask

	// Header, random body, and the length field at the two positions ending at LENGTH_OFFSET.
	task automatic send_frame(input logic [15:0] length_value, input int unsigned beats);
		logic [7:0] b;
		for (int i = 0; i < beats; i++) begin
			if (i == 0)
				b = cur_header;
			else if (i == LENGTH_OFFSET - 2)
				b = length_value[15:8];
			else if (i == LENGTH_OFFSET - 1)
				b = length_value[7:0];
			else
				b = 8'($urandom_range(0, 255));
			send_byte(b);
		end
	endtask

	task automatic set_header(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_header = value;
		header_writes++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (beats_outstanding != 0);
	endtask

	task automatic random_traffic(input int unsigned budget);
		int unsigned spent;
		int unsigned pick;
		int unsigned flen;
		logic [8:0]  freed;
		spent = 0;
		while (spent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				flen = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) :
					$urandom_range(5, 20);
				send_frame(flen[15:0], flen);
				spent += flen;
			end else if (pick < 53) begin
				// Broken frames: cut short, a length already passed, or one never reached.
				case ($urandom_range(0, 2))
					0: begin
						flen = $urandom_range(8, 30);
						send_frame(flen[15:0], $urandom_range(1, flen - 1));
					end
					1: send_frame(16'($urandom_range(0, LENGTH_OFFSET)),
						$urandom_range(LENGTH_OFFSET, 10));
					default: send_frame(16'($urandom_range(16'hFF00, 16'hFFFF)),
						$urandom_range(LENGTH_OFFSET, 10));
				endcase
				spent += 6;
			end else if (pick < 88) begin
				if ($urandom_range(0, 11) == 0)
					freed = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(0, 256));
				else
					freed = 9'($urandom_range(0, 24));
				send_release(freed);
				spent++;
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [7:0] hdr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_header(8'h7E);
		send_byte(8'h55);
		send_release(9'd0);
		// A seven-byte frame carrying both data extremes.
		send_byte(8'h7E); send_byte(8'h00); send_byte(8'h00); send_byte(8'h07);
		send_byte(8'hFF); send_byte(8'h12); send_byte(8'h34);
		send_release(9'd256);
		// A release arriving in the middle of a frame leaves the frame alone.
		send_byte(8'h7E); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h06);
		send_release(9'd3);
		send_byte(8'h11); send_byte(8'h22);
		send_release(9'd1);
		send_release(9'd1);
		// Shortest frame that can complete.
		send_byte(8'h7E); send_byte(8'h55); send_byte(8'h00); send_byte(8'h05);
		send_byte(8'hA5);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: hdr = 8'h00;
				1: hdr = 8'hFF;
				default: hdr = 8'($urandom_range(0, 255));
			endcase
			set_header(hdr);
			random_traffic(PHASE_BUDGET);
			drain();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d input beats under %0d header settings;", beats_sent,
			header_writes);
		$display("%0d frames completed, %0d discarded.", frames_completed,
			frames_discarded);
		if (fail_count == 0)
			$display("[header_length_frame_receiver] OK");
		else
			$display("[header_length_frame_receiver] ERROR");
		$finish;
	end

endmodule
